[rtl/core/bra_pkg.sv]
// Shared constants and codes for the resource allocator core.
package bra_pkg;

  localparam int unsigned DefMaxCustomers = 16;
  localparam int unsigned DefMaxResources = 4;
  localparam int unsigned DefAmountWidth  = 16;
  localparam int unsigned NumLanes        = 4;
  localparam int unsigned FieldWidth      = 16;

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;
  localparam logic [1:0] MODE_SETAV   = 2'd3;

  localparam logic [3:0] ST_GRANTED    = 4'd0;
  localparam logic [3:0] ST_EXC_NEED   = 4'd1;
  localparam logic [3:0] ST_INSUFF     = 4'd2;
  localparam logic [3:0] ST_UNSAFE     = 4'd3;
  localparam logic [3:0] ST_RELEASED   = 4'd4;
  localparam logic [3:0] ST_EXC_ALLOC  = 4'd5;
  localparam logic [3:0] ST_LOADED     = 4'd6;
  localparam logic [3:0] ST_AVAIL_SET  = 4'd7;
  localparam logic [3:0] ST_BAD_CUST   = 4'd8;

  localparam logic CFG_CUSTOMERS = 1'b0;
  localparam logic CFG_RESOURCES = 1'b1;

endpackage

[rtl/core/bankers_resource_allocator_core.sv]
// Top level of the banker's algorithm resource allocator core.
// Set available and bad customer go straight to the result; release, load and a request
// denied at the checks read and evaluate the customer row first; a request passing the
// checks then scans up to P passes of N row reads, P <= N (N = customers in use).
// One item at a time: busy is high from accept to result strobe.
// After reset a clearing pass writes zero to every row.
module bankers_resource_allocator_core
  import bra_pkg::*;
#(
  parameter int unsigned MAX_CUSTOMERS = DefMaxCustomers,
  parameter int unsigned MAX_RESOURCES = DefMaxResources,
  parameter int unsigned AMOUNT_WIDTH  = DefAmountWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [3:0]            in_customer,
  input  logic [FieldWidth-1:0] in_amount_0,
  input  logic [FieldWidth-1:0] in_amount_1,
  input  logic [FieldWidth-1:0] in_amount_2,
  input  logic [FieldWidth-1:0] in_amount_3,
  output logic                  out_valid,
  output logic [3:0]            out_status,
  output logic [FieldWidth-1:0] out_available_0,
  output logic [FieldWidth-1:0] out_available_1,
  output logic [FieldWidth-1:0] out_available_2,
  output logic [FieldWidth-1:0] out_available_3,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:2]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned AW  = AMOUNT_WIDTH;
  localparam int unsigned NR  = MAX_RESOURCES;
  localparam int unsigned CW  = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
  localparam int unsigned NCW = $clog2(MAX_CUSTOMERS + 1);
  localparam int unsigned RW  = 2 * NR * AW;
  localparam int unsigned WW  = AW + 7;  // work vector never exceeds MAX_CUSTOMERS + 1 amounts
  localparam logic [AW-1:0] AMAX = '1;

  // state codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;  // row read issued for customer
  localparam logic [2:0] S_EVAL  = 3'd3;  // row data present
  localparam logic [2:0] S_SCAN  = 3'd4;  // safety scan, one row per cycle
  localparam logic [2:0] S_DONE  = 3'd5;

  // config registers
  logic [4:0] cust_cfg_r;
  logic [2:0] res_cfg_r;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_RESOURCES) prdata[2:0] = res_cfg_r;
    else                           prdata[4:0] = cust_cfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cust_cfg_r <= 5'd16;
      res_cfg_r  <= 3'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == CFG_RESOURCES) res_cfg_r  <= pwdata[2:0];
      else                           cust_cfg_r <= pwdata[4:0];
    end
  end

  // effective counts
  logic [NCW-1:0] nc;
  logic [2:0]     nr;
  always_comb begin
    if (cust_cfg_r == 5'd0) nc = NCW'(1);
    else if (32'(cust_cfg_r) > MAX_CUSTOMERS) nc = NCW'(MAX_CUSTOMERS);
    else nc = NCW'(cust_cfg_r);
    if (res_cfg_r == 3'd0) nr = 3'd1;
    else if (32'(res_cfg_r) > NR) nr = 3'(NR);
    else nr = res_cfg_r;
  end

  // datapath registers
  logic [2:0]    state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [CW-1:0] cust_r;
  logic [AW-1:0] amt_r   [NR];
  logic [AW-1:0] avail_r [NR];
  logic [AW-1:0] tavail_r[NR];   // tentative available
  logic [RW-1:0] trow_r;         // tentative row of the requesting customer
  logic [WW-1:0] work_r  [NR];
  logic [MAX_CUSTOMERS-1:0] done_r;
  logic [NCW-1:0] fin_r;
  logic           prog_r;
  logic [CW-1:0]  scan_r;        // row whose data is present in S_SCAN
  logic [CW:0]    clr_r;
  logic [3:0]     stat_r;
  logic           outv_r;

  // memory
  logic          we;
  logic [CW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  bra_row_mem #(.MaxCustomers(MAX_CUSTOMERS), .RowWidth(RW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] need_of(input logic [RW-1:0] row, input int j);
    need_of = row[j*AW +: AW];
  endfunction
  function automatic logic [AW-1:0] alloc_of(input logic [RW-1:0] row, input int j);
    alloc_of = row[(NR+j)*AW +: AW];
  endfunction
  function automatic logic [AW-1:0] sadd(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sadd = s[AW] ? AMAX : s[AW-1:0];
  endfunction

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // row under evaluation during scan: the requester's row comes from the tentative copy
  logic [RW-1:0] srow;
  assign srow = (scan_r == cust_r) ? trow_r : rdata;

  // row evaluation for request, release and load, plus the scan fit test
  logic exc_need, insuff, exc_alloc, fits;
  logic [RW-1:0] req_row, rel_row, load_row;
  always_comb begin
    exc_need = 1'b0; insuff = 1'b0; exc_alloc = 1'b0; fits = 1'b1;
    req_row = rdata; rel_row = rdata; load_row = rdata;
    for (int j = 0; j < NR; j++) begin
      if (j < int'(nr)) begin
        if (amt_r[j] > need_of(rdata, j))  exc_need  = 1'b1;
        if (amt_r[j] > avail_r[j])         insuff    = 1'b1;
        if (amt_r[j] > alloc_of(rdata, j)) exc_alloc = 1'b1;
        if (WW'(need_of(srow, j)) > work_r[j]) fits = 1'b0;
        req_row[j*AW +: AW]      = need_of(rdata, j) - amt_r[j];
        req_row[(NR+j)*AW +: AW] = sadd(alloc_of(rdata, j), amt_r[j]);
        rel_row[j*AW +: AW]      = sadd(need_of(rdata, j), amt_r[j]);
        rel_row[(NR+j)*AW +: AW] = alloc_of(rdata, j) - amt_r[j];
        load_row[j*AW +: AW]      = amt_r[j];
        load_row[(NR+j)*AW +: AW] = '0;
      end
    end
  end

  logic scan_hit, last_row;
  assign scan_hit = !done_r[scan_r] && fits;
  assign last_row = ({1'b0, scan_r} == (CW+1)'(nc - NCW'(1)));

  always_comb begin
    state_nxt = state_r;
    we = 1'b0; waddr = cust_r; wdata = '0; raddr = cust_r;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r[CW-1:0];
        if (32'(clr_r) == MAX_CUSTOMERS - 1) state_nxt = S_IDLE;
      end
      S_IDLE: if (accept) begin
        raddr = CW'(in_customer);
        if (in_mode == MODE_SETAV || 32'(in_customer) >= 32'(nc)) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_DONE;
        if (mode_r == MODE_RELEASE) begin
          we = !exc_alloc; wdata = rel_row;
        end else if (mode_r == MODE_LOAD) begin
          we = 1'b1; wdata = load_row;
        end else if (!exc_need && !insuff) begin
          state_nxt = S_SCAN; raddr = '0;
        end
      end
      S_SCAN: begin
        raddr = last_row ? '0 : scan_r + CW'(1);
        if (fin_r + NCW'(scan_hit) == nc) begin
          state_nxt = S_DONE; we = 1'b1; wdata = trow_r;
        end else if (last_row && !(prog_r || scan_hit)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      outv_r  <= 1'b0;
      for (int j = 0; j < NR; j++) avail_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= 1'b0;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + (CW+1)'(1);
        S_IDLE: if (accept) begin
          mode_r <= in_mode;
          cust_r <= CW'(in_customer);
          amt_r[0] <= AW'(in_amount_0);
          if (NR > 1) amt_r[1 % NR] <= AW'(in_amount_1);
          if (NR > 2) amt_r[2 % NR] <= AW'(in_amount_2);
          if (NR > 3) amt_r[3 % NR] <= AW'(in_amount_3);
          if (in_mode == MODE_SETAV) begin
            stat_r <= ST_AVAIL_SET;
            if (nr > 3'd0) avail_r[0] <= AW'(in_amount_0);
            if (NR > 1 && nr > 3'd1) avail_r[1 % NR] <= AW'(in_amount_1);
            if (NR > 2 && nr > 3'd2) avail_r[2 % NR] <= AW'(in_amount_2);
            if (NR > 3 && nr > 3'd3) avail_r[3 % NR] <= AW'(in_amount_3);
          end else begin
            stat_r <= ST_BAD_CUST;
          end
        end
        S_RD: ;
        S_EVAL: begin
          done_r <= '0; fin_r <= '0; prog_r <= 1'b0; scan_r <= '0;
          trow_r <= req_row;
          for (int j = 0; j < NR; j++) begin
            tavail_r[j] <= avail_r[j] - ((j < int'(nr)) ? amt_r[j] : '0);
            work_r[j]   <= WW'(avail_r[j] - ((j < int'(nr)) ? amt_r[j] : '0));
          end
          if (mode_r == MODE_RELEASE) begin
            stat_r <= exc_alloc ? ST_EXC_ALLOC : ST_RELEASED;
            if (!exc_alloc)
              for (int j = 0; j < NR; j++)
                if (j < int'(nr)) avail_r[j] <= sadd(avail_r[j], amt_r[j]);
          end else if (mode_r == MODE_LOAD) begin
            stat_r <= ST_LOADED;
          end else begin
            stat_r <= exc_need ? ST_EXC_NEED : (insuff ? ST_INSUFF : ST_UNSAFE);
          end
        end
        S_SCAN: begin
          scan_r <= last_row ? '0 : scan_r + CW'(1);
          prog_r <= last_row ? 1'b0 : (prog_r || scan_hit);
          if (scan_hit) begin
            done_r[scan_r] <= 1'b1;
            fin_r <= fin_r + NCW'(1);
            for (int j = 0; j < NR; j++)
              if (j < int'(nr)) work_r[j] <= work_r[j] + WW'(alloc_of(srow, j));
          end
          if (fin_r + NCW'(scan_hit) == nc) begin
            stat_r <= ST_GRANTED;
            for (int j = 0; j < NR; j++) avail_r[j] <= tavail_r[j];
          end
        end
        S_DONE: outv_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // result beat
  logic [FieldWidth-1:0] av_out [NumLanes];
  always_comb begin
    for (int j = 0; j < NumLanes; j++) begin
      av_out[j] = '0;
      if (j < NR) av_out[j] = FieldWidth'(avail_r[j % NR]);
    end
  end
  assign out_valid       = outv_r;
  assign out_status      = stat_r;
  assign out_available_0 = av_out[0];
  assign out_available_1 = av_out[1];
  assign out_available_2 = av_out[2];
  assign out_available_3 = av_out[3];

  // checks
  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without an item in flight");
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> fin_r < nc) else $error("finish count overran");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BAD_CUST) else $error("bad status code");

endmodule

[rtl/core/bra_row_mem.sv]
// Row-wide synchronous memory: need and allocation rows for all customers.
module bra_row_mem
  import bra_pkg::*;
#(
  parameter int unsigned MaxCustomers = DefMaxCustomers,
  parameter int unsigned RowWidth     = 2 * DefMaxResources * DefAmountWidth,
  localparam int unsigned AddrWidth   = (MaxCustomers > 1) ? $clog2(MaxCustomers) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrWidth-1:0] waddr,
  input  logic [RowWidth-1:0]  wdata,
  input  logic [AddrWidth-1:0] raddr,
  output logic [RowWidth-1:0]  rdata
);

  logic [RowWidth-1:0] mem [MaxCustomers];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/tb_bankers_resource_allocator_core.sv]
// Testbench for the banker's algorithm resource allocator core: directed and random stimulus,
// with a model of the allocation tables that predicts every result beat.
module tb_bankers_resource_allocator_core;
  import bra_pkg::*;

  localparam int unsigned NCUST = 16;
  localparam int unsigned NRES = 4;
  localparam logic [15:0] AMAX = 16'hFFFF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] av0;
    logic [15:0] av1;
    logic [15:0] av2;
    logic [15:0] av3;
  } alloc_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic [3:0] in_customer;
  logic [15:0] in_amount_0, in_amount_1, in_amount_2, in_amount_3;
  logic out_valid;
  logic [3:0] out_status;
  logic [15:0] out_available_0, out_available_1, out_available_2, out_available_3;
  logic psel, penable, pwrite;
  logic [2:2] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bankers_resource_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_customer(in_customer),
    .in_amount_0(in_amount_0), .in_amount_1(in_amount_1),
    .in_amount_2(in_amount_2), .in_amount_3(in_amount_3),
    .out_valid(out_valid), .out_status(out_status),
    .out_available_0(out_available_0), .out_available_1(out_available_1),
    .out_available_2(out_available_2), .out_available_3(out_available_3),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model state: configuration registers and the three tables.
  logic [4:0]  cust_reg;
  logic [2:0]  res_reg;
  logic [15:0] avail_vec [NRES];
  logic [15:0] need_tab  [NCUST][NRES];
  logic [15:0] alloc_tab [NCUST][NRES];

  alloc_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned eff_cust();
    if (cust_reg == 0) return 1;
    if (cust_reg > NCUST) return NCUST;
    return 32'(cust_reg);
  endfunction

  function automatic int unsigned eff_res();
    if (res_reg == 0) return 1;
    if (res_reg > NRES) return NRES;
    return 32'(res_reg);
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? AMAX : s[15:0];
  endfunction

  function automatic void model_reset();
    cust_reg = 5'd16;
    res_reg = 3'd4;
    for (int j = 0; j < NRES; j++) avail_vec[j] = '0;
    for (int i = 0; i < NCUST; i++)
      for (int j = 0; j < NRES; j++) begin
        need_tab[i][j] = '0;
        alloc_tab[i][j] = '0;
      end
  endfunction

  // Safety scan over a tentative state: repeat passes until every customer
  // finishes or a pass makes no progress.
  function automatic bit state_safe(logic [15:0] av[NRES], logic [15:0] nd[NCUST][NRES],
                                    logic [15:0] al[NCUST][NRES], int unsigned nc,
                                    int unsigned nr);
    longint unsigned work[NRES];
    bit done[NCUST];
    int unsigned finished;
    bit progress;
    bit fits;
    finished = 0;
    for (int j = 0; j < NRES; j++) work[j] = 64'(av[j]);
    for (int i = 0; i < NCUST; i++) done[i] = 1'b0;
    while (finished < nc) begin
      progress = 1'b0;
      for (int i = 0; i < nc; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++) if (nd[i][j] > work[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < nr; j++) work[j] += 64'(al[i][j]);
            done[i] = 1'b1;
            finished++;
            progress = 1'b1;
          end
        end
      end
      if (!progress) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic alloc_result_t allocator_predict(logic [1:0] mode, logic [3:0] c,
                                                      logic [15:0] amt[NRES]);
    alloc_result_t r;
    int unsigned nc, nr;
    logic [3:0] st;
    logic [15:0] tav[NRES];
    logic [15:0] tnd[NCUST][NRES];
    logic [15:0] tal[NCUST][NRES];
    nc = eff_cust();
    nr = eff_res();
    if (mode == MODE_SETAV) begin
      for (int j = 0; j < nr; j++) avail_vec[j] = amt[j];
      st = ST_AVAIL_SET;
    end else if (c >= nc) begin
      st = ST_BAD_CUST;
    end else if (mode == MODE_REQUEST) begin
      st = ST_GRANTED;
      for (int j = 0; j < nr; j++) if (amt[j] > need_tab[c][j]) st = ST_EXC_NEED;
      if (st == ST_GRANTED)
        for (int j = 0; j < nr; j++) if (amt[j] > avail_vec[j]) st = ST_INSUFF;
      if (st == ST_GRANTED) begin
        tav = avail_vec;
        tnd = need_tab;
        tal = alloc_tab;
        for (int j = 0; j < nr; j++) begin
          tav[j] = tav[j] - amt[j];
          tnd[c][j] = tnd[c][j] - amt[j];
          tal[c][j] = sat16(tal[c][j], amt[j]);
        end
        if (state_safe(tav, tnd, tal, nc, nr)) begin
          avail_vec = tav;
          need_tab = tnd;
          alloc_tab = tal;
        end else begin
          st = ST_UNSAFE;
        end
      end
    end else if (mode == MODE_RELEASE) begin
      st = ST_RELEASED;
      for (int j = 0; j < nr; j++) if (amt[j] > alloc_tab[c][j]) st = ST_EXC_ALLOC;
      if (st == ST_RELEASED)
        for (int j = 0; j < nr; j++) begin
          avail_vec[j] = sat16(avail_vec[j], amt[j]);
          alloc_tab[c][j] = alloc_tab[c][j] - amt[j];
          need_tab[c][j] = sat16(need_tab[c][j], amt[j]);
        end
    end else begin
      for (int j = 0; j < nr; j++) begin
        need_tab[c][j] = amt[j];
        alloc_tab[c][j] = '0;
      end
      st = ST_LOADED;
    end
    r.status = st;
    r.av0 = avail_vec[0];
    r.av1 = avail_vec[1];
    r.av2 = avail_vec[2];
    r.av3 = avail_vec[3];
    return r;
  endfunction

  // Result checker: every strobed beat is matched against the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending, status %0d", out_status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_available_0 !== exp_r.av0) begin
          $error("available_0 expected %0h actual %0h", exp_r.av0, out_available_0);
          fail_count++;
        end
        if (out_available_1 !== exp_r.av1) begin
          $error("available_1 expected %0h actual %0h", exp_r.av1, out_available_1);
          fail_count++;
        end
        if (out_available_2 !== exp_r.av2) begin
          $error("available_2 expected %0h actual %0h", exp_r.av2, out_available_2);
          fail_count++;
        end
        if (out_available_3 !== exp_r.av3) begin
          $error("available_3 expected %0h actual %0h", exp_r.av3, out_available_3);
          fail_count++;
        end
      end
    end
  end

  // Send one command beat; start stays high until the core takes it.
  task automatic send_item(logic [1:0] mode, logic [3:0] c, logic [15:0] a0,
                           logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
    logic [15:0] amt[NRES];
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_mode = mode;
    in_customer = c;
    in_amount_0 = a0;
    in_amount_1 = a1;
    in_amount_2 = a2;
    in_amount_3 = a3;
    start = 1'b1;
    do @(posedge clk); while (busy);
    amt[0] = a0;
    amt[1] = a1;
    amt[2] = a2;
    amt[3] = a3;
    pending_results.push_back(allocator_predict(mode, c, amt));
  endtask

  task automatic send_all(logic [1:0] mode, logic [3:0] c, logic [15:0] a);
    send_item(mode, c, a, a, a, a);
  endtask

  // Drain: drop start, wait for every prediction to be met, then let the core settle.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = idx;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == CFG_CUSTOMERS) cust_reg = data[4:0];
    else res_reg = data[2:0];
  endtask

  task automatic set_config(logic [31:0] ncust, logic [31:0] nres);
    wait_idle();
    write_register(CFG_CUSTOMERS, ncust);
    write_register(CFG_RESOURCES, nres);
  endtask

  // Reset state: zero tables; zero request and release succeed, nonzero exceed need or allocation.
  task automatic test_reset_state();
    send_all(MODE_REQUEST, 4'd0, 16'd0);
    send_all(MODE_REQUEST, 4'd15, 16'd1);
    send_all(MODE_RELEASE, 4'd3, 16'd1);
    send_all(MODE_RELEASE, 4'd3, 16'd0);
  endtask

  // Every mode with field extremes, plus the exceed-need, insufficient and exceed-allocation denials.
  task automatic test_modes_extremes();
    send_all(MODE_SETAV, 4'd9, AMAX);
    send_all(MODE_LOAD, 4'd15, AMAX);
    send_all(MODE_REQUEST, 4'd15, AMAX);
    send_all(MODE_RELEASE, 4'd15, AMAX);
    send_all(MODE_SETAV, 4'd0, 16'd3);
    send_all(MODE_LOAD, 4'd1, 16'd8);
    send_item(MODE_REQUEST, 4'd1, 16'd9, 16'd0, 16'd0, 16'd0);
    send_item(MODE_REQUEST, 4'd1, 16'd0, 16'd0, 16'd0, 16'd4);
    send_all(MODE_REQUEST, 4'd1, 16'd3);
    send_item(MODE_RELEASE, 4'd1, 16'd0, 16'd4, 16'd0, 16'd0);
    send_all(MODE_RELEASE, 4'd1, 16'd2);
    send_all(MODE_SETAV, 4'd0, 16'd0);
  endtask

  // Rollback on an unsafe state, saturation on release, customer out of range.
  task automatic test_unsafe_and_saturation();
    set_config(32'd2, 32'd4);
    send_all(MODE_SETAV, 4'd0, 16'd5);
    send_all(MODE_LOAD, 4'd0, 16'd10);
    send_all(MODE_LOAD, 4'd1, 16'd10);
    send_all(MODE_REQUEST, 4'd0, 16'd5);
    send_all(MODE_LOAD, 4'd2, 16'd1);
    send_all(MODE_RELEASE, 4'd7, 16'd0);
    send_all(MODE_SETAV, 4'd0, 16'd20);
    send_all(MODE_REQUEST, 4'd0, 16'd10);
    send_all(MODE_SETAV, 4'd0, AMAX);
    send_all(MODE_RELEASE, 4'd0, 16'd10);
  endtask

  function automatic logic [15:0] pick_up_to(logic [15:0] lim);
    if ($urandom_range(0, 9) == 0) return lim;
    return 16'($urandom_range(0, lim));
  endfunction

  // One random phase: mostly consistent traffic built from the model state,
  // with a share of noise across the full field ranges.
  task automatic random_phase(int unsigned count);
    int unsigned nc;
    logic [3:0] c;
    logic [15:0] a[NRES];
    logic [15:0] lim;
    int unsigned kind;
    nc = eff_cust();
    send_item(MODE_SETAV, 4'($urandom), 16'($urandom_range(200, 2000)),
              16'($urandom_range(200, 2000)), 16'($urandom_range(200, 2000)),
              16'($urandom_range(200, 2000)));
    for (int i = 0; i < nc; i++)
      send_item(MODE_LOAD, 4'(i), 16'($urandom_range(0, 900)), 16'($urandom_range(0, 900)),
                16'($urandom_range(0, 900)), 16'($urandom_range(0, 900)));
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      c = 4'($urandom_range(0, nc - 1));
      if (kind < 45) begin
        for (int j = 0; j < NRES; j++) begin
          lim = need_tab[c][j] < avail_vec[j] ? need_tab[c][j] : avail_vec[j];
          a[j] = pick_up_to(lim);
        end
        send_item(MODE_REQUEST, c, a[0], a[1], a[2], a[3]);
      end else if (kind < 70) begin
        for (int j = 0; j < NRES; j++) a[j] = pick_up_to(alloc_tab[c][j]);
        send_item(MODE_RELEASE, c, a[0], a[1], a[2], a[3]);
      end else if (kind < 76) begin
        send_item(MODE_LOAD, c, 16'($urandom_range(0, 900)), 16'($urandom_range(0, 900)),
                  16'($urandom_range(0, 900)), 16'($urandom_range(0, 900)));
      end else if (kind < 80) begin
        send_item(MODE_SETAV, 4'($urandom), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 3000)));
      end else begin
        send_item(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Random traffic across register settings, out-of-range values included.
  task automatic test_random_traffic();
    set_config(32'd16, 32'd4);
    random_phase(45);
    set_config(32'd1, 32'd1);
    random_phase(30);
    set_config(32'd0, 32'd0);
    random_phase(30);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(40);
    set_config(32'd3, 32'd2);
    random_phase(45);
    set_config(32'd5, 32'd3);
    random_phase(45);
    set_config($urandom, $urandom);
    random_phase(30);
    gaps_on = 1'b0;
    set_config(32'd6, 32'd4);
    random_phase(45);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_REQUEST;
    in_customer = '0;
    in_amount_0 = '0;
    in_amount_1 = '0;
    in_amount_2 = '0;
    in_amount_3 = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = CFG_CUSTOMERS;
    pwdata = '0;
    model_reset();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_modes_extremes();
    test_unsafe_and_saturation();
    test_random_traffic();

    wait_idle();
    repeat (400) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
